// ----- sv/ncs_pkg.sv -----
// shared types, widths and codes for the nearest-center cluster statistics block
package ncs_pkg;

  localparam int MAX_CLUSTERS = 8;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int DIMS         = 3;
  localparam int COMP_W       = 2;
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 20;
  localparam int CNT_W        = COUNT_BITS + 1;
  localparam int SUM_W        = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W         = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_SQ_W    = 2 * SAMPLE_BITS;
  localparam int DIST_W       = PROD_SQ_W + 2;
  localparam int CC_W         = 4;
  localparam int FLOOR_W      = 48;
  localparam int MEAN_W       = 24;
  localparam int VAR_W        = 48;
  localparam int PRIOR_W      = 17;
  localparam int MEAN_FRAC    = 8;
  localparam int VAR_FRAC     = 16;
  localparam int PRIOR_FRAC   = 16;

  // shared multiplier and divider
  localparam int MUL_A_W      = SUM_W;
  localparam int MUL_B_W      = 26;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int Y_SPLIT      = SUM_W / 2;
  localparam int X_W          = CNT_W + SQ_W;
  localparam int ACC_W        = X_W + 2;
  localparam int DEN_W        = 2 * CNT_W;
  localparam int QUO_W        = 48;

  localparam int FUNC_W       = 2;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_TDATA_W  = 240;
  localparam int OUT_PAD_W    = OUT_TDATA_W - IDX_W - DIMS * (MEAN_W + VAR_W) - PRIOR_W;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  localparam logic REG_CLUSTER_COUNT  = 1'b0;
  localparam logic REG_VARIANCE_FLOOR = 1'b1;

  localparam logic [CC_W-1:0]    CC_RESET    = 4'd8;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 48'd65536;

  localparam logic [2:0] MUL_X_LO = 3'd0;
  localparam logic [2:0] MUL_X_HI = 3'd1;
  localparam logic [2:0] MUL_Y_LO = 3'd2;
  localparam logic [2:0] MUL_Y_HI = 3'd3;
  localparam logic [2:0] MUL_DEN  = 3'd4;

  typedef enum logic [1:0] {
    KIND_MEAN,
    KIND_VAR,
    KIND_PRIOR
  } kind_e;

  typedef struct packed {
    logic             load_center;
    logic             latch_sample;
    logic             scan_en;
    logic             sq_en;
    logic             accumulate;
    logic             clear_acc;
    logic [IDX_W-1:0] idx;
    logic [COMP_W-1:0] comp;
    logic             mul_en;
    logic [2:0]       mul_step;
    logic             div_start;
    logic             store;
    kind_e            kind;
    logic             emit;
    logic             last;
  } ncs_cmd_t;

  typedef struct packed {
    logic             total_zero;
    logic             total_full;
    logic [IDX_W-1:0] k_m1;
    logic             div_done;
    logic             out_free;
  } ncs_status_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]          pad;
    logic [PRIOR_W-1:0]            prior;
    logic [DIMS-1:0][VAR_W-1:0]    variance;
    logic [DIMS-1:0][MEAN_W-1:0]   mean;
    logic [IDX_W-1:0]              cluster_id;
  } ncs_rec_t;

endpackage

// ----- sv/ncs_div.sv -----
// restoring divider, one quotient bit per cycle
module ncs_div import ncs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] hi_i,
  input  logic [QUO_W-1:0] lo_i,
  input  logic [DEN_W-1:0] dvs_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CW = $clog2(QUO_W);
  localparam logic [CW-1:0] LAST = CW'(QUO_W - 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, dvs_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   r, diff;
  logic             ge;

  always_comb begin
    r     = {rem_q, quo_q[QUO_W-1]};
    ge    = r >= {1'b0, dvs_q};
    diff  = r - {1'b0, dvs_q};
    rem_d = ge ? diff[DEN_W-1:0] : r[DEN_W-1:0];
    quo_d = {quo_q[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      quo_q <= lo_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/ncs_dp.sv -----
// datapath: centers, accumulators, distance scan, multiplier, divider and output register
module ncs_dp import ncs_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_index_i,
  input  logic [FLOOR_W-1:0]               cfg_data_i,
  input  logic [IDX_W-1:0]                 in_slot_i,
  input  logic [DIMS-1:0][SAMPLE_BITS-1:0] in_comp_i,
  input  ncs_cmd_t                         cmd_i,
  output ncs_status_t                      status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output ncs_rec_t                         out_rec_o,
  output logic                             out_last_o
);

  logic [CC_W-1:0]    cc_q;
  logic [FLOOR_W-1:0] floor_q;
  logic [IDX_W-1:0]   k_m1;

  logic [DIMS-1:0][SAMPLE_BITS-1:0] center_q [MAX_CLUSTERS];
  logic [DIMS-1:0][SAMPLE_BITS-1:0] samp_q;
  logic [DIMS-1:0][SAMPLE_BITS-1:0] op;
  logic [DIMS-1:0][PROD_SQ_W-1:0]   p_q;
  logic                             cmp_v_q;
  logic [IDX_W-1:0]                 cmp_idx_q, best_q;
  logic [DIST_W-1:0]                dist_sum, best_d_q;

  logic [CNT_W-1:0]           cnt_q [MAX_CLUSTERS];
  logic [DIMS-1:0][SUM_W-1:0] sum_q [MAX_CLUSTERS];
  logic [DIMS-1:0][SQ_W-1:0]  sq_q  [MAX_CLUSTERS];
  logic [CNT_W-1:0]           total_q;

  logic [IDX_W-1:0] rd;
  logic [CNT_W-1:0] n;
  logic [SUM_W-1:0] s1;
  logic [SQ_W-1:0]  s2;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_q;
  logic [DEN_W-1:0]   den_q;
  logic               neg_q, sat_q;

  logic [DEN_W-1:0] div_hi, div_dvs;
  logic [QUO_W-1:0] div_lo, quo;
  logic             div_done;

  logic [DIMS-1:0][MEAN_W-1:0] mean_q;
  logic [DIMS-1:0][VAR_W-1:0]  var_q;
  logic [PRIOR_W-1:0]          prior_q;
  logic                        out_valid_q, out_last_q;
  ncs_rec_t                    rec_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= CC_RESET;
      floor_q <= FLOOR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLUSTER_COUNT:  cc_q    <= cfg_data_i[CC_W-1:0];
        REG_VARIANCE_FLOOR: floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cc_q == '0) begin
      k_m1 = '0;
    end else if (cc_q > CC_W'(MAX_CLUSTERS)) begin
      k_m1 = IDX_W'(MAX_CLUSTERS - 1);
    end else begin
      k_m1 = IDX_W'(cc_q - 1'b1);
    end
  end

  // center table and sample latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_center) begin
      center_q[in_slot_i] <= in_comp_i;
    end
    if (cmd_i.latch_sample) begin
      samp_q <= in_comp_i;
    end
  end

  // distance scan: squares registered, then summed and compared
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      if (cmd_i.sq_en) begin
        op[d] = samp_q[d];
      end else if (samp_q[d] >= center_q[cmd_i.idx][d]) begin
        op[d] = samp_q[d] - center_q[cmd_i.idx][d];
      end else begin
        op[d] = center_q[cmd_i.idx][d] - samp_q[d];
      end
    end
    dist_sum = '0;
    for (int d = 0; d < DIMS; d++) begin
      dist_sum = dist_sum + DIST_W'(p_q[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en || cmd_i.sq_en) begin
      for (int d = 0; d < DIMS; d++) begin
        p_q[d] <= op[d] * op[d];
      end
    end
    cmp_idx_q <= cmd_i.idx;
    if (cmp_v_q && (cmp_idx_q == '0 || dist_sum < best_d_q)) begin
      best_d_q <= dist_sum;
      best_q   <= cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_en;
    end
  end

  // accumulators
  assign rd = cmd_i.accumulate ? best_q : cmd_i.idx;
  assign n  = cnt_q[rd];
  assign s1 = sum_q[rd][cmd_i.comp];
  assign s2 = sq_q[rd][cmd_i.comp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < MAX_CLUSTERS; g++) begin
        cnt_q[g] <= '0;
        sum_q[g] <= '0;
        sq_q[g]  <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.clear_acc) begin
      for (int g = 0; g < MAX_CLUSTERS; g++) begin
        cnt_q[g] <= '0;
        sum_q[g] <= '0;
        sq_q[g]  <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.accumulate) begin
      cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
      for (int d = 0; d < DIMS; d++) begin
        sum_q[best_q][d] <= sum_q[best_q][d] + SUM_W'(samp_q[d]);
        sq_q[best_q][d]  <= sq_q[best_q][d] + SQ_W'(p_q[d]);
      end
      total_q <= total_q + 1'b1;
    end
  end

  // variance numerator n*s2 - s1^2 and denominator n^2, one partial product a cycle
  always_comb begin
    case (cmd_i.mul_step)
      MUL_X_LO: begin
        mul_a = MUL_A_W'(n);
        mul_b = s2[MUL_B_W-1:0];
      end
      MUL_X_HI: begin
        mul_a = MUL_A_W'(n);
        mul_b = s2[SQ_W-1:MUL_B_W];
      end
      MUL_Y_LO: begin
        mul_a = s1;
        mul_b = MUL_B_W'(s1[Y_SPLIT-1:0]);
      end
      MUL_Y_HI: begin
        mul_a = s1;
        mul_b = MUL_B_W'(s1[SUM_W-1:Y_SPLIT]);
      end
      MUL_DEN: begin
        mul_a = MUL_A_W'(n);
        mul_b = MUL_B_W'(n);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        MUL_X_LO: acc_q <= ACC_W'(prod);
        MUL_X_HI: acc_q <= acc_q + (ACC_W'(prod) << MUL_B_W);
        MUL_Y_LO: acc_q <= acc_q - ACC_W'(prod);
        MUL_Y_HI: acc_q <= acc_q - (ACC_W'(prod) << Y_SPLIT);
        MUL_DEN:  den_q <= prod[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // divider operands
  always_comb begin
    case (cmd_i.kind)
      KIND_MEAN: begin
        div_hi  = '0;
        div_lo  = QUO_W'({s1, {MEAN_FRAC{1'b0}}});
        div_dvs = DEN_W'(n);
      end
      KIND_VAR: begin
        div_hi  = DEN_W'(acc_q[X_W-1:QUO_W-VAR_FRAC]);
        div_lo  = {acc_q[QUO_W-VAR_FRAC-1:0], {VAR_FRAC{1'b0}}};
        div_dvs = den_q;
      end
      KIND_PRIOR: begin
        div_hi  = '0;
        div_lo  = QUO_W'({n, {PRIOR_FRAC{1'b0}}});
        div_dvs = DEN_W'(total_q);
      end
      default: begin
        div_hi  = '0;
        div_lo  = '0;
        div_dvs = '0;
      end
    endcase
  end

  ncs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // variance: a quotient of 2^48 or more saturates; a negative numerator gives zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && cmd_i.kind == KIND_VAR) begin
      neg_q <= acc_q[ACC_W-1];
      sat_q <= div_hi >= den_q;
    end
    if (cmd_i.store) begin
      case (cmd_i.kind)
        KIND_MEAN: mean_q[cmd_i.comp] <= (n == '0) ? '0 : quo[MEAN_W-1:0];
        KIND_VAR: begin
          if (n < CNT_W'(2)) begin
            var_q[cmd_i.comp] <= floor_q;
          end else if (neg_q) begin
            var_q[cmd_i.comp] <= '0;
          end else if (sat_q) begin
            var_q[cmd_i.comp] <= '1;
          end else begin
            var_q[cmd_i.comp] <= quo[VAR_W-1:0];
          end
        end
        KIND_PRIOR: prior_q <= quo[PRIOR_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rec_q.pad        <= '0;
      rec_q.prior      <= prior_q;
      rec_q.variance   <= var_q;
      rec_q.mean       <= mean_q;
      rec_q.cluster_id <= cmd_i.idx;
      out_last_q       <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = rec_q;
  assign out_last_o  = out_last_q;

  assign status_o.total_zero = (total_q == '0);
  assign status_o.total_full = total_q[COUNT_BITS];
  assign status_o.k_m1       = k_m1;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- sv/ncs_ctrl.sv -----
// controller state machine sequencing loads, sample scans and the finish pass
module ncs_ctrl import ncs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] in_func_i,
  output logic              in_ready_o,
  input  ncs_status_t       status_i,
  output ncs_cmd_t          cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_VMUL  = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VWAIT = 4'd8;
  localparam logic [3:0] S_PRIOR = 4'd9;
  localparam logic [3:0] S_PWAIT = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_CLEAR = 4'd12;

  localparam logic [COMP_W-1:0] LAST_COMP = COMP_W'(DIMS - 1);

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic [2:0]        step_q, step_d;
  logic              fire;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    comp_d  = comp_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.idx      = idx_q;
    cmd_o.comp     = comp_q;
    cmd_o.mul_step = step_q;
    cmd_o.kind     = KIND_MEAN;
    in_ready_o = (state_q == S_IDLE);
    fire       = in_valid_i && in_ready_o;

    case (state_q)
      S_IDLE: begin
        if (fire) begin
          case (in_func_i)
            FUNC_LOAD: cmd_o.load_center = 1'b1;
            FUNC_SAMPLE: begin
              if (!status_i.total_full) begin
                cmd_o.latch_sample = 1'b1;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            FUNC_FINISH: begin
              if (!status_i.total_zero) begin
                idx_d   = '0;
                comp_d  = '0;
                state_d = S_MEAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (idx_q == status_i.k_m1) begin
          state_d = S_SQ;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d = S_IDLE;
      end
      S_MEAN: begin
        cmd_o.div_start = 1'b1;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (status_i.div_done) begin
          cmd_o.store = 1'b1;
          if (comp_q == LAST_COMP) begin
            comp_d  = '0;
            step_d  = MUL_X_LO;
            state_d = S_VMUL;
          end else begin
            comp_d  = comp_q + 1'b1;
            state_d = S_MEAN;
          end
        end
      end
      S_VMUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == MUL_DEN) begin
          state_d = S_VDIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_VDIV: begin
        cmd_o.kind      = KIND_VAR;
        cmd_o.div_start = 1'b1;
        state_d = S_VWAIT;
      end
      S_VWAIT: begin
        cmd_o.kind = KIND_VAR;
        if (status_i.div_done) begin
          cmd_o.store = 1'b1;
          if (comp_q == LAST_COMP) begin
            state_d = S_PRIOR;
          end else begin
            comp_d  = comp_q + 1'b1;
            step_d  = MUL_X_LO;
            state_d = S_VMUL;
          end
        end
      end
      S_PRIOR: begin
        cmd_o.kind      = KIND_PRIOR;
        cmd_o.div_start = 1'b1;
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        cmd_o.kind = KIND_PRIOR;
        if (status_i.div_done) begin
          cmd_o.store = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = (idx_q == status_i.k_m1);
          if (idx_q == status_i.k_m1) begin
            state_d = S_CLEAR;
          end else begin
            idx_d   = idx_q + 1'b1;
            comp_d  = '0;
            state_d = S_MEAN;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clear_acc = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      comp_q  <= '0;
      step_q  <= MUL_X_LO;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      comp_q  <= comp_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- sv/nearest_center_cluster_stats_core.sv -----
// top level of the nearest-center cluster statistics block
//
// Input stream: tuser carries the function (load center, add sample, finish),
// tdata the center slot and the three components. Configuration writes go
// through the cfg channel (index 0 cluster count, index 1 variance floor),
// which is always ready; write only while the block is idle.
// A sample scans the k active clusters, one center distance a cycle, then
// takes a squaring and an accumulate step. A finish runs each active cluster
// through the shared serial divider seven times and the shared multiplier
// five times per component: the three means, then the three variances, then
// the prior, and then the record is handed over. One record per cluster
// leaves on the output stream, tlast on the final one; accumulators then
// clear. A finish with no samples produces nothing.
// The input is taken only between items. A stalled receiver holds the
// record in the output register and the finish pass waits for it; the next
// item is accepted while the final record still waits.
// Reset clears the accumulators and sample total and returns the
// configuration registers to their defaults; center slots hold nothing until loaded.
module nearest_center_cluster_stats_core import ncs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // center_slot[2:0], comp_a[18:3], comp_b[34:19], comp_c[50:35], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // func[1:0]
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // cluster_id[2:0], mean_a[26:3], mean_b[50:27], mean_c[74:51], var_a[122:75],
  // var_b[170:123], var_c[218:171], prior_fraction[235:219], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // last_cluster
  output logic                   m_axis_tlast_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [FLOOR_W-1:0]     cfg_data_i
);

  ncs_cmd_t                         cmd;
  ncs_status_t                      status;
  ncs_rec_t                         rec;
  logic [DIMS-1:0][SAMPLE_BITS-1:0] in_comp;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      in_comp[d] = s_axis_tdata_i[IDX_W + d*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  assign cfg_ready_o = 1'b1;

  ncs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ncs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_slot_i   (s_axis_tdata_i[IDX_W-1:0]),
    .in_comp_i   (in_comp),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_rec_o   (rec),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = rec;

endmodule

// ----- sv/ncs_checker.sv -----
// port-level checks for the nearest-center cluster statistics block, bound to the top
module ncs_checker import ncs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [FUNC_W-1:0]      s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int PRIOR_LSB = IDX_W + DIMS * (MEAN_W + VAR_W);
  localparam logic [PRIOR_W-1:0] PRIOR_ONE = PRIOR_W'(1) << PRIOR_FRAC;

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_prior_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[PRIOR_LSB +: PRIOR_W] <= PRIOR_ONE))
    else $error("prior above one");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i == FUNC_SAMPLE) |=> !s_axis_tready_o)
    else $error("input taken during sample scan");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i == FUNC_LOAD) |=> s_axis_tready_o)
    else $error("center load left input blocked");

endmodule

bind nearest_center_cluster_stats_core ncs_checker u_ncs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- sim/tb_nearest_center_cluster_stats_core.sv -----
// testbench for the nearest-center cluster statistics block
module tb_nearest_center_cluster_stats_core;
  import ncs_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam int RANDOM_ITEMS = 480;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  typedef struct packed {
    ncs_rec_t rec;
    logic     last;
  } cluster_rec_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  slot;
    logic [15:0]       a, b, c;
    bit                chk;
    logic [PRIOR_W-1:0] exp_prior;
    logic [VAR_W-1:0]   exp_var;
  } stim_row_t;

  logic clk, rst_ni;
  logic s_tvalid, s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0] s_tuser;
  logic m_tvalid, m_tready, m_tlast;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [FLOOR_W-1:0] cfg_data;

  nearest_center_cluster_stats_core dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [15:0]        center_q[MAX_CLUSTERS][DIMS];
  logic [CNT_W-1:0]   members_q[MAX_CLUSTERS];
  logic [SUM_W-1:0]   sum_q[MAX_CLUSTERS][DIMS];
  logic [SQ_W-1:0]    sumsq_q[MAX_CLUSTERS][DIMS];
  logic [CNT_W-1:0]   total_q;
  logic [CC_W-1:0]    cc_q;
  logic [FLOOR_W-1:0] floor_q;

  cluster_rec_t pending_recs[$];
  int  errors, items_sent, recs_seen, finishes, cfg_writes;
  bit  quiet;
  longint cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAR_W-1:0] spread_of(logic [CNT_W-1:0] n, logic [SUM_W-1:0] s1,
                                                logic [SQ_W-1:0] s2);
    logic [127:0] x, y, q;
    x = 128'(n) * 128'(s2);
    y = 128'(s1) * 128'(s1);
    if (x < y) return '0;
    q = ((x - y) << VAR_FRAC) / (128'(n) * 128'(n));
    return (q > 128'(VAR_MAX)) ? VAR_MAX : q[VAR_W-1:0];
  endfunction

  function automatic int active_count();
    if (cc_q == 0) return 1;
    if (cc_q > MAX_CLUSTERS) return MAX_CLUSTERS;
    return int'(cc_q);
  endfunction

  // update the predicted state for one accepted item, queue any records it causes
  function automatic void predict_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] slot,
                                       logic [15:0] a, logic [15:0] b, logic [15:0] c);
    logic [15:0] comp[DIMS];
    longint unsigned sq_dist, best_dist, diff;
    int k, best;
    cluster_rec_t r;
    comp[0] = a; comp[1] = b; comp[2] = c;
    k = active_count();
    case (func)
      FUNC_LOAD: begin
        for (int d = 0; d < DIMS; d++) center_q[slot][d] = comp[d];
      end
      FUNC_SAMPLE: begin
        if (total_q >= (1 << COUNT_BITS)) return;
        best = 0; best_dist = 0;
        for (int g = 0; g < k; g++) begin
          sq_dist = 0;
          for (int d = 0; d < DIMS; d++) begin
            diff = (comp[d] >= center_q[g][d]) ? comp[d] - center_q[g][d]
                                               : center_q[g][d] - comp[d];
            sq_dist += diff * diff;
          end
          if (g == 0 || sq_dist < best_dist) begin
            best_dist = sq_dist;
            best = g;
          end
        end
        members_q[best]++;
        for (int d = 0; d < DIMS; d++) begin
          sum_q[best][d] += comp[d];
          sumsq_q[best][d] += 52'(comp[d]) * 52'(comp[d]);
        end
        total_q++;
      end
      FUNC_FINISH: begin
        if (total_q == 0) return;
        for (int g = 0; g < k; g++) begin
          r = '0;
          r.rec.cluster_id = IDX_W'(g);
          for (int d = 0; d < DIMS; d++) begin
            r.rec.mean[d] = (members_q[g] >= 1) ?
              MEAN_W'((64'(sum_q[g][d]) << MEAN_FRAC) / members_q[g]) : '0;
            r.rec.variance[d] = (members_q[g] >= 2) ?
              spread_of(members_q[g], sum_q[g][d], sumsq_q[g][d]) : floor_q;
          end
          r.rec.prior = PRIOR_W'((64'(members_q[g]) << PRIOR_FRAC) / total_q);
          r.last = (g + 1 == k);
          pending_recs.insert(pending_recs.size(), r);
        end
        for (int g = 0; g < MAX_CLUSTERS; g++) begin
          members_q[g] = '0;
          for (int d = 0; d < DIMS; d++) begin
            sum_q[g][d] = '0;
            sumsq_q[g][d] = '0;
          end
        end
        total_q = '0;
        finishes++;
      end
      default: ;
    endcase
  endfunction

  // entered at a rising edge; returns at the edge where the item was taken
  task automatic send_item(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] slot,
                           logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'b0, c, b, a, slot};
    do @(posedge clk); while (!s_tready);
    predict_item(func, slot, a, b, c);
    if (func != FUNC_SPARE) items_sent++;
  endtask

  // let the block go idle: every record in, then the tail of a sample
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [FLOOR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CLUSTER_COUNT) cc_q = value[CC_W-1:0];
    else floor_q = value;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [15:0] near_value(logic [15:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 600) - 300;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(1 << $urandom_range(0, 15));
      default: return 16'hFFFF ^ 16'(1 << $urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_sample();
    int g, mode;
    logic [15:0] v[DIMS];
    g = $urandom_range(0, MAX_CLUSTERS - 1);
    mode = $urandom_range(0, 9);
    for (int d = 0; d < DIMS; d++) begin
      if (mode < 7) v[d] = near_value(center_q[g][d]);
      else if (mode < 9) v[d] = 16'($urandom_range(0, 65535));
      else v[d] = edge_value();
    end
    send_item(FUNC_SAMPLE, IDX_W'($urandom_range(0, 7)), v[0], v[1], v[2]);
  endtask

  // output checker
  always @(posedge clk) begin
    cluster_rec_t want;
    ncs_rec_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      recs_seen++;
      if (pending_recs.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, cluster %0d", $time, got.cluster_id);
      end else begin
        want = pending_recs.pop_front();
        if (got.cluster_id !== want.rec.cluster_id) begin
          errors++;
          $display("%0t: cluster_id exp %0d got %0d", $time, want.rec.cluster_id,
                   got.cluster_id);
        end
        for (int d = 0; d < DIMS; d++) begin
          if (got.mean[d] !== want.rec.mean[d]) begin
            errors++;
            $display("%0t: cluster %0d mean[%0d] exp %h got %h", $time,
                     want.rec.cluster_id, d, want.rec.mean[d], got.mean[d]);
          end
          if (got.variance[d] !== want.rec.variance[d]) begin
            errors++;
            $display("%0t: cluster %0d variance[%0d] exp %h got %h", $time,
                     want.rec.cluster_id, d, want.rec.variance[d], got.variance[d]);
          end
        end
        if (got.prior !== want.rec.prior) begin
          errors++;
          $display("%0t: cluster %0d prior exp %h got %h", $time, want.rec.cluster_id,
                   want.rec.prior, got.prior);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: cluster %0d tlast exp %b got %b", $time, want.rec.cluster_id,
                   want.last, m_tlast);
        end
      end
    end
  end

  // receiver stalls
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_center_cluster_stats_core verification failed");
      $finish;
    end
  end

  stim_row_t rows[$];

  function automatic void add_row(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] s,
                                  logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                  bit chk = 0, logic [PRIOR_W-1:0] ep = '0,
                                  logic [VAR_W-1:0] ev = '0);
    stim_row_t r;
    r.func = f; r.slot = s; r.a = a; r.b = b; r.c = c;
    r.chk = chk; r.exp_prior = ep; r.exp_var = ev;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    int first, n;
    errors = 0; items_sent = 0; recs_seen = 0; finishes = 0; cfg_writes = 0;
    cycles = 0; stall_left = 0; quiet = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    m_tready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    cc_q = CC_RESET; floor_q = FLOOR_RESET; total_q = '0;
    for (int g = 0; g < MAX_CLUSTERS; g++) begin
      members_q[g] = '0;
      for (int d = 0; d < DIMS; d++) begin
        center_q[g][d] = '0; sum_q[g][d] = '0; sumsq_q[g][d] = '0;
      end
    end
    rst_ni = 0;
    repeat (7) @(posedge clk);
    rst_ni <= 1;
    @(posedge clk);

    // empty finish, all slots loaded, ties, unused code, lone member
    add_row(FUNC_FINISH, 0, 0, 0, 0);
    add_row(FUNC_LOAD, 0, 16'h0000, 16'h0000, 16'h0000);
    add_row(FUNC_LOAD, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_row(FUNC_LOAD, 2, 16'h5555, 16'h5555, 16'h5555);
    add_row(FUNC_LOAD, 3, 16'hAAAA, 16'hAAAA, 16'hAAAA);
    add_row(FUNC_LOAD, 4, 16'd1000, 16'd1000, 16'd1000);
    add_row(FUNC_LOAD, 5, 16'd1000, 16'd1000, 16'd1000);
    add_row(FUNC_LOAD, 6, 16'hFFFF, 16'h0000, 16'hFFFF);
    add_row(FUNC_LOAD, 7, 16'h0000, 16'hFFFF, 16'h0000);
    add_row(FUNC_SAMPLE, 0, 16'h0000, 16'h0000, 16'h0000);
    add_row(FUNC_SAMPLE, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_row(FUNC_SAMPLE, 0, 16'd1000, 16'd1000, 16'd1000);
    add_row(FUNC_SPARE, 5, 16'h1234, 16'h5678, 16'h9ABC);
    add_row(FUNC_SAMPLE, 0, 16'd1001, 16'd999, 16'd1000);
    add_row(FUNC_SAMPLE, 0, 16'hFFFF, 16'h0000, 16'hFFFE);
    add_row(FUNC_FINISH, 0, 0, 0, 0);
    add_row(FUNC_SAMPLE, 0, 16'h0000, 16'h0000, 16'h0000);
    // one sample in cluster 0: full prior, variance at the reset floor
    add_row(FUNC_FINISH, 0, 0, 0, 0, 1, 17'd65536, 48'd65536);
    add_row(FUNC_FINISH, 0, 0, 0, 0);

    foreach (rows[i]) begin
      // an empty queue keeps the index of the first new record fixed
      if (rows[i].chk) drain();
      first = pending_recs.size();
      send_item(rows[i].func, rows[i].slot, rows[i].a, rows[i].b, rows[i].c);
      if (rows[i].chk && (pending_recs.size() <= first ||
          pending_recs[first].rec.prior !== rows[i].exp_prior ||
          pending_recs[first].rec.variance[0] !== rows[i].exp_var)) begin
        errors++;
        $display("%0t: lone member row %0d exp prior %h variance %h", $time, i,
                 rows[i].exp_prior, rows[i].exp_var);
      end
    end
    drain();

    // configuration extremes first, then random settings
    for (int round = 0; items_sent < RANDOM_ITEMS; round++) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (round < 4 || $urandom_range(0, 2) == 0) begin
        drain();
        case (round)
          0: begin write_reg(REG_CLUSTER_COUNT, 0); write_reg(REG_VARIANCE_FLOOR, VAR_MAX); end
          1: begin write_reg(REG_CLUSTER_COUNT, 15); write_reg(REG_VARIANCE_FLOOR, 0); end
          2: begin write_reg(REG_CLUSTER_COUNT, 1); write_reg(REG_VARIANCE_FLOOR, 48'h5A5A_A5A5_5A5A); end
          3: begin write_reg(REG_CLUSTER_COUNT, 8); write_reg(REG_VARIANCE_FLOOR, 48'hA5A5_5A5A_A5A5); end
          default: begin
            if ($urandom_range(0, 1)) write_reg(REG_CLUSTER_COUNT, $urandom_range(0, 15));
            if ($urandom_range(0, 1))
              write_reg(REG_VARIANCE_FLOOR, {16'($urandom_range(0, 65535)), $urandom});
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          send_item(FUNC_LOAD, IDX_W'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int s = 0; s < n; s++) begin
        send_sample();
        if ($urandom_range(0, 24) == 0)
          send_item(FUNC_SPARE, IDX_W'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                    16'($urandom));
        // fewer active clusters while collecting
        if (s == n / 2 && $urandom_range(0, 7) == 0) begin
          drain();
          write_reg(REG_CLUSTER_COUNT, $urandom_range(1, 3));
        end
      end
      send_item(FUNC_FINISH, IDX_W'($urandom_range(0, 7)), 0, 0, 0);
      if ($urandom_range(0, 9) == 0) send_item(FUNC_FINISH, 0, 0, 0, 0);
    end
    quiet = 0;
    drain();

    $display("%0d items sent, %0d finishes, %0d cluster records checked", items_sent,
             finishes, recs_seen);
    $display("%0d register writes across cluster counts 0..15 and floor extremes",
             cfg_writes);
    if (errors == 0 && pending_recs.size() == 0) begin
      $display("nearest_center_cluster_stats_core verification clean");
    end else begin
      $display("nearest_center_cluster_stats_core verification failed");
    end
    $finish;
  end

endmodule
